FILE: rtl/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

   localparam int QueueDepthDefault = 4;
   localparam int CsrIndexWidth     = 2;
   localparam int CsrDataWidth      = 64;
   localparam int FrontStages       = 9;
   localparam int DivSteps          = 64;
   localparam int PostStages        = 6;
   localparam int BackStages        = DivSteps + 1 + PostStages;

   localparam logic [32:0] TFineOffset = 33'd128000;
   localparam logic [20:0] RawFull     = 21'd1048576;
   localparam logic [11:0] DivScale    = 12'd3125;
   localparam logic [63:0] DenBias     = 64'h0000_8000_0000_0000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TEMP_CALIB = 2'd0,
      CSR_PRESS_LOW  = 2'd1,
      CSR_PRESS_HIGH = 2'd2,
      CSR_PRESS_NINE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } calib_type;

   typedef struct packed {
      logic [31:0] temperature_centi;
      logic [31:0] fine_temperature;
      logic [63:0] dividend_mag;
      logic [30:0] divisor_mag;
      logic        quot_neg;
      logic        invalid;
   } div_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // (fine * 5 + 128) >>> 8, 32-bit wrapping
   function automatic logic [31:0] temp_from_fine(input logic [31:0] fine);
      logic [31:0] sum;
      sum = fine + {fine[29:0], 2'b00} + 32'd128;
      return $signed(sum) >>> 8;
   endfunction

endpackage

FILE: rtl/bpc_front.sv
`timescale 1ns / 1ps

module bpc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  bpc_pkg::calib_type       calib,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [19:0]              in_raw_pressure,
   input  logic [19:0]              in_raw_temperature,
   output logic                     out_valid,
   output bpc_pkg::div_job_type     out_job
);

   logic [bpc_pkg::FrontStages-1:0] vld_ff;

   logic signed [17:0] s1_a_in, s1_a_ff, s1_b_in, s1_b_ff;
   logic [19:0]        adcp_ff [1:7];

   logic signed [33:0] s2_m1_full;
   logic signed [35:0] s2_m2_full;
   logic [31:0]        s2_m1_ff, s2_m2_ff;

   logic signed [31:0] s3_x1_in, s3_x1_ff, s3_m2_shr;
   logic signed [35:0] s3_m3_full;
   logic [31:0]        s3_m3_ff;

   logic signed [31:0] s4_x2;
   logic [31:0]        s4_fine_in, s4_fine_ff;

   logic [31:0]        s5_temp_in, s5_fine_in;
   logic signed [32:0] s5_v1_in, s5_v1_ff;
   logic [31:0]        temp_ff [5:8];
   logic [31:0]        fine_ff [5:8];

   logic signed [65:0] s6_sq_full;
   logic signed [48:0] s6_pv5_in, s6_pv2_in, s6_pv5_ff, s6_pv2_ff;
   logic [63:0]        s6_sq_ff;

   logic signed [79:0] s7_prod6, s7_prod3;
   logic signed [63:0] s7_prod3_lo, s7_p3_shr;
   logic [63:0]        s7_v2_in, s7_u_in, s7_v2_ff, s7_u_ff;

   logic [20:0]        s8_pp;
   logic [63:0]        s8_diff, s8_num_in, s8_den_base, s8_num_ff, s8_den_ff;
   logic [79:0]        s8_den_full;

   logic [30:0]        s9_dv;
   bpc_pkg::div_job_type s9_job_in, s9_job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[bpc_pkg::FrontStages-2:0], in_valid};
      end
   end

   // temperature
   assign s1_a_in = $signed({1'b0, in_raw_temperature[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
   assign s1_b_in = $signed({2'b00, in_raw_temperature[19:4]}) - $signed({2'b00, calib.t1});

   assign s2_m1_full = s1_a_ff * $signed(calib.t2);
   assign s2_m2_full = s1_b_ff * s1_b_ff;

   assign s3_x1_in   = $signed(s2_m1_ff) >>> 11;
   assign s3_m2_shr  = $signed(s2_m2_ff) >>> 12;
   assign s3_m3_full = $signed(s3_m2_shr[19:0]) * $signed(calib.t3);

   assign s4_x2      = $signed(s3_m3_ff) >>> 14;
   assign s4_fine_in = s3_x1_ff + s4_x2;

   assign s5_temp_in = bpc_pkg::temp_from_fine(s4_fine_ff);
   assign s5_fine_in = s4_fine_ff;
   assign s5_v1_in   = $signed({s4_fine_ff[31], s4_fine_ff}) - $signed(bpc_pkg::TFineOffset);

   // pressure coefficients, 64-bit wrapping
   assign s6_sq_full = s5_v1_ff * s5_v1_ff;
   assign s6_pv5_in  = s5_v1_ff * $signed(calib.p5);
   assign s6_pv2_in  = s5_v1_ff * $signed(calib.p2);

   assign s7_prod6    = $signed(s6_sq_ff) * $signed(calib.p6);
   assign s7_prod3    = $signed(s6_sq_ff) * $signed(calib.p3);
   assign s7_prod3_lo = s7_prod3[63:0];
   assign s7_p3_shr   = s7_prod3_lo >>> 8;
   assign s7_v2_in    = s7_prod6[63:0]
                      + ({{15{s6_pv5_ff[48]}}, s6_pv5_ff} << 17)
                      + ({{48{calib.p4[15]}}, calib.p4} << 35);
   assign s7_u_in     = s7_p3_shr + ({{15{s6_pv2_ff[48]}}, s6_pv2_ff} << 12);

   assign s8_pp       = bpc_pkg::RawFull - {1'b0, adcp_ff[7]};
   assign s8_diff     = {12'd0, s8_pp, 31'd0} - s7_v2_ff;
   assign s8_num_in   = s8_diff * {52'd0, bpc_pkg::DivScale};
   assign s8_den_base = bpc_pkg::DenBias + s7_u_ff;
   assign s8_den_full = s8_den_base * calib.p1;

   // divider operands as sign and magnitude
   assign s9_dv = s8_den_ff[63:33];

   always_comb begin
      s9_job_in.temperature_centi = temp_ff[8];
      s9_job_in.fine_temperature  = fine_ff[8];
      s9_job_in.invalid           = (s9_dv == '0);
      s9_job_in.quot_neg          = s8_num_ff[63] ^ s9_dv[30];
      s9_job_in.dividend_mag      = s8_num_ff[63] ? (64'd0 - s8_num_ff) : s8_num_ff;
      s9_job_in.divisor_mag       = s9_dv[30] ? (31'd0 - s9_dv) : s9_dv;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_a_ff    <= s1_a_in;
         s1_b_ff    <= s1_b_in;
         adcp_ff[1] <= in_raw_pressure;
         for (int k = 2; k <= 7; k++) begin
            adcp_ff[k] <= adcp_ff[k-1];
         end
         s2_m1_ff   <= s2_m1_full[31:0];
         s2_m2_ff   <= s2_m2_full[31:0];
         s3_x1_ff   <= s3_x1_in;
         s3_m3_ff   <= s3_m3_full[31:0];
         s4_fine_ff <= s4_fine_in;
         s5_v1_ff   <= s5_v1_in;
         temp_ff[5] <= s5_temp_in;
         fine_ff[5] <= s5_fine_in;
         for (int k = 6; k <= 8; k++) begin
            temp_ff[k] <= temp_ff[k-1];
            fine_ff[k] <= fine_ff[k-1];
         end
         s6_sq_ff   <= s6_sq_full[63:0];
         s6_pv5_ff  <= s6_pv5_in;
         s6_pv2_ff  <= s6_pv2_in;
         s7_v2_ff   <= s7_v2_in;
         s7_u_ff    <= s7_u_in;
         s8_num_ff  <= s8_num_in;
         s8_den_ff  <= s8_den_full[63:0];
         s9_job_ff  <= s9_job_in;
      end
   end

   assign out_valid = vld_ff[bpc_pkg::FrontStages-1];
   assign out_job   = s9_job_ff;

endmodule

FILE: rtl/bpc_queue.sv
`timescale 1ns / 1ps

module bpc_queue #(
   parameter int Depth = bpc_pkg::QueueDepthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bpc_pkg::div_job_type       push_data,
   input  logic                       pop,
   output bpc_pkg::div_job_type       head_data,
   output bpc_pkg::queue_status_type  status
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   bpc_pkg::div_job_type mem_ff [Depth];

   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CountWidth'(Depth));
   assign status.empty = (count_ff == '0);

endmodule

FILE: rtl/bpc_back.sv
`timescale 1ns / 1ps

module bpc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bpc_pkg::calib_type    calib,
   input  logic                  in_valid,
   input  bpc_pkg::div_job_type  in_job,
   output logic                  in_take,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [31:0]           out_temperature_centi,
   output logic [31:0]           out_fine_temperature,
   output logic [31:0]           out_pressure_q24_8,
   output logic                  out_pressure_invalid
);

   typedef struct packed {
      logic [30:0] rem;
      logic [63:0] nq;
      logic [30:0] da;
      logic        quot_neg;
      logic        invalid;
      logic [31:0] temp;
      logic [31:0] fine;
   } div_stage_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic        invalid;
   } meta_type;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type r;
      logic [31:0]   trial;
      logic          qbit;
      r     = s;
      trial = {s.rem, s.nq[63]};
      qbit  = (trial >= {1'b0, s.da});
      r.rem = qbit ? 31'(trial - {1'b0, s.da}) : trial[30:0];
      r.nq  = {s.nq[62:0], qbit};
      return r;
   endfunction

   logic [bpc_pkg::BackStages-1:0] vld_ff;
   logic                            advance;

   div_stage_type dv_ff [0:bpc_pkg::DivSteps];
   div_stage_type dv_in [1:bpc_pkg::DivSteps];
   div_stage_type dv_load;
   meta_type      meta_ff [1:5];

   logic [63:0]        p1_p_in, p1_p_ff, p2_p_ff, p3_p_ff, p4_p_ff;
   logic signed [63:0] p2_q13_in;
   logic signed [79:0] p2_m9_full, p2_w2_full;
   logic [63:0]        p2_q13_ff, p2_m9_ff, p2_w2f_ff, p3_w2f_ff, p4_w2f_ff;
   logic [63:0]        p3_ll_in, p3_lh_full, p3_hl_full, p3_ll_ff;
   logic [31:0]        p3_lh_ff, p3_hl_ff;
   logic [63:0]        p4_w1p_in, p4_w1p_ff;
   logic signed [63:0] p5_w1_shr, p5_w2_shr, p5_sum, p5_sum_shr;
   logic [63:0]        p5_s_in, p5_s_ff;
   logic [31:0]        p6_press_in;

   logic [31:0] out_temp_ff, out_fine_ff, out_press_ff;
   logic        out_invalid_ff;

   assign advance = !(vld_ff[bpc_pkg::BackStages-1] && out_stall);
   assign in_take = advance && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[bpc_pkg::BackStages-2:0], in_valid};
      end
   end

   always_comb begin
      dv_load.rem      = '0;
      dv_load.nq       = in_job.dividend_mag;
      dv_load.da       = in_job.divisor_mag;
      dv_load.quot_neg = in_job.quot_neg;
      dv_load.invalid  = in_job.invalid;
      dv_load.temp     = in_job.temperature_centi;
      dv_load.fine     = in_job.fine_temperature;
   end

   // one quotient bit per stage
   always_comb begin
      for (int k = 1; k <= bpc_pkg::DivSteps; k++) begin
         dv_in[k] = div_step(dv_ff[k-1]);
      end
   end

   assign p1_p_in = dv_ff[bpc_pkg::DivSteps].quot_neg ?
                    (64'd0 - dv_ff[bpc_pkg::DivSteps].nq) : dv_ff[bpc_pkg::DivSteps].nq;

   assign p2_q13_in  = $signed(p1_p_ff) >>> 13;
   assign p2_m9_full = p2_q13_in * $signed(calib.p9);
   assign p2_w2_full = $signed(p1_p_ff) * $signed(calib.p8);

   // low 64 bits of m9 * q13 from 32-bit partial products
   assign p3_ll_in   = p2_m9_ff[31:0] * p2_q13_ff[31:0];
   assign p3_lh_full = p2_m9_ff[31:0] * p2_q13_ff[63:32];
   assign p3_hl_full = p2_m9_ff[63:32] * p2_q13_ff[31:0];

   assign p4_w1p_in = p3_ll_ff + {32'(p3_lh_ff + p3_hl_ff), 32'd0};

   assign p5_w1_shr  = $signed(p4_w1p_ff) >>> 25;
   assign p5_w2_shr  = $signed(p4_w2f_ff) >>> 19;
   assign p5_sum     = $signed(p4_p_ff) + p5_w1_shr + p5_w2_shr;
   assign p5_sum_shr = p5_sum >>> 8;
   assign p5_s_in    = p5_sum_shr + ({{48{calib.p7[15]}}, calib.p7} << 4);

   always_comb begin
      if (meta_ff[5].invalid || p5_s_ff[63]) begin
         p6_press_in = '0;
      end else if (|p5_s_ff[62:32]) begin
         p6_press_in = '1;
      end else begin
         p6_press_in = p5_s_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_ff[0] <= dv_load;
         for (int k = 1; k <= bpc_pkg::DivSteps; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         meta_ff[1].temp    <= dv_ff[bpc_pkg::DivSteps].temp;
         meta_ff[1].fine    <= dv_ff[bpc_pkg::DivSteps].fine;
         meta_ff[1].invalid <= dv_ff[bpc_pkg::DivSteps].invalid;
         for (int k = 2; k <= 5; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         p1_p_ff   <= p1_p_in;
         p2_p_ff   <= p1_p_ff;
         p2_q13_ff <= p2_q13_in;
         p2_m9_ff  <= p2_m9_full[63:0];
         p2_w2f_ff <= p2_w2_full[63:0];
         p3_p_ff   <= p2_p_ff;
         p3_w2f_ff <= p2_w2f_ff;
         p3_ll_ff  <= p3_ll_in;
         p3_lh_ff  <= p3_lh_full[31:0];
         p3_hl_ff  <= p3_hl_full[31:0];
         p4_p_ff   <= p3_p_ff;
         p4_w2f_ff <= p3_w2f_ff;
         p4_w1p_ff <= p4_w1p_in;
         p5_s_ff   <= p5_s_in;
         out_temp_ff    <= meta_ff[5].temp;
         out_fine_ff    <= meta_ff[5].fine;
         out_invalid_ff <= meta_ff[5].invalid;
         out_press_ff   <= p6_press_in;
      end
   end

   assign out_valid             = vld_ff[bpc_pkg::BackStages-1];
   assign out_temperature_centi = out_temp_ff;
   assign out_fine_temperature  = out_fine_ff;
   assign out_pressure_q24_8    = out_press_ff;
   assign out_pressure_invalid  = out_invalid_ff;

endmodule

FILE: rtl/baro_temp_pressure_compensation.sv
`timescale 1ns / 1ps

// Integer temperature and pressure compensation for raw 20-bit converter
// readings. One reading pair is accepted per clock unless req_stall is high,
// and each gives one result. 9 front stages compute temperature and the
// divider operands. The job is then written into a short queue. After that
// come 65 stages of a one-bit-per-stage signed divider and 6 stages of
// pressure polishing and saturation, ending in the output register. A
// reading passes 9 + 1 + 71 register stages, and its request transfer edge
// itself loads the first one. A stalled result holds the back end only. The
// front end keeps accepting until the queue fills. Calibration words are
// written through the csr port and must only change while no reading is in
// flight. A zero divisor yields pressure 0 with the invalid flag set.
module baro_temp_pressure_compensation #(
   parameter int QueueDepth = bpc_pkg::QueueDepthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [bpc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [bpc_pkg::CsrDataWidth-1:0]   csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [19:0]                        req_raw_pressure,
   input  logic [19:0]                        req_raw_temperature,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [31:0]                        rsp_temperature_centi,
   output logic [31:0]                        rsp_fine_temperature,
   output logic [31:0]                        rsp_pressure_q24_8,
   output logic                               rsp_pressure_invalid
);

   logic [47:0] temp_calib_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_high_ff;
   logic [15:0] press_nine_ff;

   bpc_pkg::calib_type        calib;
   bpc_pkg::div_job_type      front_job, head_job;
   bpc_pkg::queue_status_type q_status;
   logic                      front_valid, front_advance, q_push, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_nine_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            bpc_pkg::CSR_TEMP_CALIB: temp_calib_ff <= csr_data[47:0];
            bpc_pkg::CSR_PRESS_LOW:  press_low_ff  <= csr_data;
            bpc_pkg::CSR_PRESS_HIGH: press_high_ff <= csr_data;
            bpc_pkg::CSR_PRESS_NINE: press_nine_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign calib.t1 = temp_calib_ff[15:0];
   assign calib.t2 = temp_calib_ff[31:16];
   assign calib.t3 = temp_calib_ff[47:32];
   assign calib.p1 = press_low_ff[15:0];
   assign calib.p2 = press_low_ff[31:16];
   assign calib.p3 = press_low_ff[47:32];
   assign calib.p4 = press_low_ff[63:48];
   assign calib.p5 = press_high_ff[15:0];
   assign calib.p6 = press_high_ff[31:16];
   assign calib.p7 = press_high_ff[47:32];
   assign calib.p8 = press_high_ff[63:48];
   assign calib.p9 = press_nine_ff;

   assign front_advance = !front_valid || !q_status.full;
   assign q_push        = front_valid && !q_status.full;
   assign req_stall     = !front_advance;

   bpc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .calib              (calib),
      .advance            (front_advance),
      .in_valid           (req_valid),
      .in_raw_pressure    (req_raw_pressure),
      .in_raw_temperature (req_raw_temperature),
      .out_valid          (front_valid),
      .out_job            (front_job)
   );

   bpc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_job),
      .pop       (q_pop),
      .head_data (head_job),
      .status    (q_status)
   );

   bpc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .calib                 (calib),
      .in_valid              (!q_status.empty),
      .in_job                (head_job),
      .in_take               (q_pop),
      .out_valid             (rsp_valid),
      .out_stall             (rsp_stall),
      .out_temperature_centi (rsp_temperature_centi),
      .out_fine_temperature  (rsp_fine_temperature),
      .out_pressure_q24_8    (rsp_pressure_q24_8),
      .out_pressure_invalid  (rsp_pressure_invalid)
   );

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_invalid |-> rsp_pressure_q24_8 == '0)
      else $error("invalid pressure transfer carries nonzero pressure");

   a_temp_matches_fine: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature_centi == bpc_pkg::temp_from_fine(rsp_fine_temperature))
      else $error("temperature and fine temperature out of step");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty together");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic [31:0] temp_centi;
      logic [31:0] fine;
      logic [31:0] press;
      logic        invalid;
   } comp_result_type;

   class comp_scoreboard;
      logic [47:0] temp_cal;
      logic [63:0] press_lo;
      logic [63:0] press_hi;
      logic [15:0] press_p9;
      comp_result_type pending[$];
      int errors;
      int checked;
      int invalid_seen;

      function new();
         temp_cal = '0;
         press_lo = '0;
         press_hi = '0;
         press_p9 = '0;
         errors = 0;
         checked = 0;
         invalid_seen = 0;
      endfunction

      function void set_reg(bpc_pkg::csr_index_type idx, logic [63:0] val);
         case (idx)
            bpc_pkg::CSR_TEMP_CALIB: temp_cal = val[47:0];
            bpc_pkg::CSR_PRESS_LOW:  press_lo = val;
            bpc_pkg::CSR_PRESS_HIGH: press_hi = val;
            bpc_pkg::CSR_PRESS_NINE: press_p9 = val[15:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] sx16(logic [15:0] w);
         return {{48{w[15]}}, w};
      endfunction

      function logic [63:0] asr(logic [63:0] v, int s);
         return $signed(v) >>> s;
      endfunction

      function comp_result_type compensate(logic [19:0] raw_p, logic [19:0] raw_t);
         comp_result_type r;
         logic [31:0] t1, t2, t3, a, b, m, x1, x2, fine;
         logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic [63:0] v1, v2, w, pr, n, na, da, q, q13, w1, w2;
         t1 = {16'd0, temp_cal[15:0]};
         t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
         t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
         a = ({12'd0, raw_t} >> 3) - (t1 << 1);
         m = a * t2;
         x1 = $signed(m) >>> 11;
         b = ({12'd0, raw_t} >> 4) - t1;
         m = b * b;
         m = $signed(m) >>> 12;
         m = m * t3;
         x2 = $signed(m) >>> 14;
         fine = x1 + x2;
         m = fine * 32'd5 + 32'd128;
         r.temp_centi = $signed(m) >>> 8;
         r.fine = fine;
         p1 = {48'd0, press_lo[15:0]};
         p2 = sx16(press_lo[31:16]);
         p3 = sx16(press_lo[47:32]);
         p4 = sx16(press_lo[63:48]);
         p5 = sx16(press_hi[15:0]);
         p6 = sx16(press_hi[31:16]);
         p7 = sx16(press_hi[47:32]);
         p8 = sx16(press_hi[63:48]);
         p9 = sx16(press_p9);
         v1 = {{32{fine[31]}}, fine} - 64'd128000;
         v2 = v1 * v1 * p6;
         w = v1 * p5;
         v2 = v2 + (w << 17);
         v2 = v2 + (p4 << 35);
         w = v1 * v1 * p3;
         n = v1 * p2;
         v1 = asr(w, 8) + (n << 12);
         w = ((64'd1 << 47) + v1) * p1;
         v1 = asr(w, 33);
         r.press = '0;
         r.invalid = 1'b0;
         if (v1 == 64'd0) begin
            r.invalid = 1'b1;
         end else begin
            pr = 64'd1048576 - {44'd0, raw_p};
            n = ((pr << 31) - v2) * 64'd3125;
            na = n[63] ? (64'd0 - n) : n;
            da = v1[63] ? (64'd0 - v1) : v1;
            q = na / da;
            pr = (n[63] != v1[63]) ? (64'd0 - q) : q;
            q13 = asr(pr, 13);
            w = p9 * q13 * q13;
            w1 = asr(w, 25);
            w = p8 * pr;
            w2 = asr(w, 19);
            w = pr + w1 + w2;
            pr = asr(w, 8) + (p7 << 4);
            if (pr[63])
               r.press = '0;
            else if (pr > 64'hFFFF_FFFF)
               r.press = 32'hFFFF_FFFF;
            else
               r.press = pr[31:0];
         end
         return r;
      endfunction

      function void note(logic [19:0] raw_p, logic [19:0] raw_t);
         pending.push_back(compensate(raw_p, raw_t));
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h expected %h", what, got, want);
         errors++;
      endtask

      task check(comp_result_type got);
         comp_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected transfer", got.press, 32'd0);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.invalid) invalid_seen++;
         if (got.temp_centi !== want.temp_centi)
            report_mismatch("temperature_centi", got.temp_centi, want.temp_centi);
         if (got.fine !== want.fine)
            report_mismatch("fine_temperature", got.fine, want.fine);
         if (got.press !== want.press)
            report_mismatch("pressure_q24_8", got.press, want.press);
         if (got.invalid !== want.invalid)
            report_mismatch("pressure_invalid", {31'd0, got.invalid}, {31'd0, want.invalid});
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [19:0] req_raw_pressure = '0;
   logic [19:0] req_raw_temperature = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_temperature_centi;
   logic [31:0] rsp_fine_temperature;
   logic [31:0] rsp_pressure_q24_8;
   logic        rsp_pressure_invalid;

   comp_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_reqs = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   baro_temp_pressure_compensation uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_raw_pressure(req_raw_pressure), .req_raw_temperature(req_raw_temperature),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_temperature_centi(rsp_temperature_centi),
      .rsp_fine_temperature(rsp_fine_temperature),
      .rsp_pressure_q24_8(rsp_pressure_q24_8),
      .rsp_pressure_invalid(rsp_pressure_invalid)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen = hold_reqs;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      comp_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note(req_raw_pressure, req_raw_temperature);
         if (rsp_valid && !rsp_stall) begin
            got.temp_centi = rsp_temperature_centi;
            got.fine = rsp_fine_temperature;
            got.press = rsp_pressure_q24_8;
            got.invalid = rsp_pressure_invalid;
            sb.check(got);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles > 3000) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   task write_reg(bpc_pkg::csr_index_type idx, logic [63:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task send_item(logic [19:0] raw_p, logic [19:0] raw_t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_pressure <= raw_p;
      req_raw_temperature <= raw_t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   function logic [19:0] rand_raw();
      int k;
      k = $urandom_range(99);
      if (k < 10) return 20'd0;
      if (k < 20) return 20'hFFFFF;
      if (k < 40) return 20'(300000 + $urandom_range(300000));
      return 20'($urandom);
   endfunction

   task load_setting(int s);
      case (s)
         0: begin
            write_reg(bpc_pkg::CSR_TEMP_CALIB, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
            write_reg(bpc_pkg::CSR_PRESS_LOW, {16'd2855, 16'd3024, 16'hD643, 16'd36477});
            write_reg(bpc_pkg::CSR_PRESS_HIGH, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
            write_reg(bpc_pkg::CSR_PRESS_NINE, 64'd6000);
         end
         1: begin
            write_reg(bpc_pkg::CSR_TEMP_CALIB, 64'd0);
            write_reg(bpc_pkg::CSR_PRESS_LOW, 64'd0);
            write_reg(bpc_pkg::CSR_PRESS_HIGH, 64'd0);
            write_reg(bpc_pkg::CSR_PRESS_NINE, 64'd0);
         end
         2: begin
            write_reg(bpc_pkg::CSR_TEMP_CALIB, '1);
            write_reg(bpc_pkg::CSR_PRESS_LOW, '1);
            write_reg(bpc_pkg::CSR_PRESS_HIGH, '1);
            write_reg(bpc_pkg::CSR_PRESS_NINE, '1);
         end
         3: begin
            write_reg(bpc_pkg::CSR_TEMP_CALIB, {16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF});
            write_reg(bpc_pkg::CSR_PRESS_LOW, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF});
            write_reg(bpc_pkg::CSR_PRESS_HIGH, {4{16'h7FFF}});
            write_reg(bpc_pkg::CSR_PRESS_NINE, 64'h7FFF);
         end
         4: begin
            write_reg(bpc_pkg::CSR_TEMP_CALIB, {16'd0, 16'h8000, 16'h8000, 16'h0001});
            write_reg(bpc_pkg::CSR_PRESS_LOW, {16'h8000, 16'h8000, 16'h8000, 16'h0001});
            write_reg(bpc_pkg::CSR_PRESS_HIGH, {4{16'h8000}});
            write_reg(bpc_pkg::CSR_PRESS_NINE, 64'h8000);
         end
         5: begin
            write_reg(bpc_pkg::CSR_TEMP_CALIB, {$urandom, $urandom});
            write_reg(bpc_pkg::CSR_PRESS_LOW, {$urandom, $urandom});
            write_reg(bpc_pkg::CSR_PRESS_HIGH, {$urandom, $urandom});
            write_reg(bpc_pkg::CSR_PRESS_NINE, {$urandom, $urandom});
         end
         default: begin
            write_reg(bpc_pkg::CSR_TEMP_CALIB, {16'd0,
                                       16'hFC18 ^ 16'($urandom_range(255)),
                                       16'd26435 ^ 16'($urandom_range(255)),
                                       16'd27504 ^ 16'($urandom_range(255))});
            write_reg(bpc_pkg::CSR_PRESS_LOW, {16'd2855, 16'd3024, 16'hD643,
                                      16'd36477 ^ 16'($urandom_range(1023))});
            write_reg(bpc_pkg::CSR_PRESS_HIGH, {$urandom, $urandom});
            write_reg(bpc_pkg::CSR_PRESS_NINE, {$urandom, $urandom});
         end
      endcase
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int s = 0; s < 7; s++) begin
         if (s < 2) begin
            send_idle_pct = 14;
            recv_idle_pct = 80;
         end else if (s < 4) begin
            send_idle_pct = 80;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_setting(s);
         if (s == 0) begin
            send_item(20'd415148, 20'd519888);
            send_item(20'd0, 20'd0);
            send_item(20'hFFFFF, 20'hFFFFF);
            send_item(20'd0, 20'hFFFFF);
            send_item(20'hFFFFF, 20'd0);
            send_item(20'h55555, 20'hAAAAA);
            send_item(20'hAAAAA, 20'h55555);
            send_item(20'd1, 20'd440000);
            send_item(20'd300000, 20'd600000);
         end
         for (int i = 0; i < 185; i++) begin
            if (s == 4 && i == 20) begin
               req_valid <= 1'b0;
               @(posedge clock);
               hold_reqs++;
               @(negedge clock);
            end
            send_item(rand_raw(), rand_raw());
         end
         drain();
      end
      $display("covered %0d results over 7 calibration settings, %0d with zero divisor",
               sb.checked, sb.invalid_seen);
      $display("idle mixes on both sides and one long output hold-off were applied");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
